// File: src/wcp_pkg.sv
`default_nettype none
package wcp_pkg;

  // field widths
  localparam int ANGLE_W  = 8;
  localparam int CTR_W    = 10;
  localparam int HALF_W   = 7;
  localparam int PIX_W    = 13;
  localparam int TRIG_W   = 10;   // signed 2.8 sine, -256..256
  localparam int COORD_W  = 12;   // rotated corner coordinate
  localparam int SUM_W    = 23;   // sum of two coord*trig products
  localparam int DEN_W    = 10;   // clamped depth
  localparam int NUM_W    = 20;   // |coord*200|
  localparam int DIV_BPS  = 2;    // quotient bits per divider stage
  localparam int DIV_STAGES  = NUM_W / DIV_BPS;
  localparam int LANE_STAGES = 4 + DIV_STAGES + 1;
  localparam int PIPE_LEN    = 1 + LANE_STAGES;

  localparam int EDGE_W     = 4;
  localparam logic [EDGE_W-1:0] LAST_EDGE = 4'd11;

  localparam int REG_ADDR_W = 4;
  localparam logic [1:0] REG_CENTER_X  = 2'd0;
  localparam logic [1:0] REG_CENTER_Y  = 2'd1;
  localparam logic [1:0] REG_HALF_SIZE = 2'd2;

  localparam logic [CTR_W-1:0]  CENTER_X_RST  = 10'd320;
  localparam logic [CTR_W-1:0]  CENTER_Y_RST  = 10'd290;
  localparam logic [HALF_W-1:0] HALF_SIZE_RST = 7'd40;

  localparam logic signed [12:0] DEPTH_BIAS = 13'sd220;
  localparam logic signed [12:0] DEPTH_MIN  = 13'sd20;
  localparam logic signed [20:0] FOCAL      = 21'sd200;

  typedef logic signed [TRIG_W-1:0] trig_val_t;

  typedef struct packed {
    trig_val_t sy;
    trig_val_t cy;
    trig_val_t sx;
    trig_val_t cx;
    trig_val_t sz;
    trig_val_t cz;
  } trig_t;

  localparam logic [8:0] QSINE [65] = '{
    9'd0,   9'd6,   9'd12,  9'd18,  9'd25,  9'd31,  9'd37,  9'd43,
    9'd49,  9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,
    9'd97,  9'd103, 9'd109, 9'd115, 9'd120, 9'd126, 9'd131, 9'd136,
    9'd142, 9'd147, 9'd152, 9'd157, 9'd162, 9'd167, 9'd171, 9'd176,
    9'd181, 9'd185, 9'd189, 9'd193, 9'd197, 9'd201, 9'd205, 9'd208,
    9'd212, 9'd215, 9'd219, 9'd222, 9'd225, 9'd228, 9'd231, 9'd233,
    9'd236, 9'd238, 9'd240, 9'd242, 9'd244, 9'd246, 9'd247, 9'd249,
    9'd250, 9'd251, 9'd252, 9'd253, 9'd254, 9'd254, 9'd255, 9'd255,
    9'd256
  };

  // quarter-wave table folded to a full turn
  function automatic trig_val_t sine8(input logic [ANGLE_W-1:0] a);
    logic [6:0] ix;
    logic [8:0] m;
    if (a <= 8'd64) ix = a[6:0];
    else if (a <= 8'd128) ix = 7'(8'd128 - a);
    else if (a <= 8'd192) ix = 7'(a - 8'd128);
    else ix = 7'(9'd256 - {1'b0, a});
    m = QSINE[ix];
    if (a > 8'd128) return -$signed({1'b0, m});
    return $signed({1'b0, m});
  endfunction

  function automatic trig_val_t cosine8(input logic [ANGLE_W-1:0] a);
    return sine8(a + 8'd64);
  endfunction

  // corner index -> +1 (1) or -1 (0) per axis
  function automatic logic [2:0] corner_signs(input logic [2:0] c);
    logic sx, sy;
    sx = (c[1:0] == 2'd1) || (c[1:0] == 2'd2);
    sy = c[1];
    return {c[2], sy, sx};
  endfunction

  function automatic logic [5:0] edge_corners(input logic [EDGE_W-1:0] e);
    logic [5:0] r;
    unique case (e)
      4'd0:    r = {3'd0, 3'd1};
      4'd1:    r = {3'd1, 3'd2};
      4'd2:    r = {3'd2, 3'd3};
      4'd3:    r = {3'd3, 3'd0};
      4'd4:    r = {3'd4, 3'd5};
      4'd5:    r = {3'd5, 3'd6};
      4'd6:    r = {3'd6, 3'd7};
      4'd7:    r = {3'd7, 3'd4};
      4'd8:    r = {3'd0, 3'd4};
      4'd9:    r = {3'd1, 3'd5};
      4'd10:   r = {3'd2, 3'd6};
      4'd11:   r = {3'd3, 3'd7};
      default: r = {3'd0, 3'd0};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/wcp_if.sv
`default_nettype none
interface wcp_in_if;
  logic                       valid;
  logic                       ready;
  logic [wcp_pkg::ANGLE_W-1:0] yaw_angle;
  logic [wcp_pkg::ANGLE_W-1:0] pitch_angle;
  logic [wcp_pkg::ANGLE_W-1:0] roll_angle;
  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface wcp_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [wcp_pkg::PIX_W-1:0] start_x;
  logic signed [wcp_pkg::PIX_W-1:0] start_y;
  logic signed [wcp_pkg::PIX_W-1:0] end_x;
  logic signed [wcp_pkg::PIX_W-1:0] end_y;
  logic                              last_edge;
  modport source (output valid, start_x, start_y, end_x, end_y, last_edge, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, last_edge, output ready);
endinterface
`default_nettype wire

// File: src/wcp_div.sv
`default_nettype none
// Pipelined restoring divider, DIV_BPS quotient bits per stage.
module wcp_div (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [wcp_pkg::NUM_W-1:0] num,
  input  wire logic [wcp_pkg::DEN_W-1:0] den,
  input  wire logic                      neg,
  output logic      [wcp_pkg::NUM_W-1:0] quo,
  output logic                           quo_neg
);
  import wcp_pkg::*;

  logic [DEN_W:0]   rem [DIV_STAGES+1];
  logic [NUM_W-1:0] nq  [DIV_STAGES+1];
  logic [DEN_W-1:0] dv  [DIV_STAGES+1];
  logic             ng  [DIV_STAGES+1];

  assign rem[0] = '0;
  assign nq[0]  = num;
  assign dv[0]  = den;
  assign ng[0]  = neg;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DEN_W:0]   r_next;
    logic [NUM_W-1:0] q_next;
    logic [DEN_W:0]   t;

    // shift in numerator bits, subtract where the divisor fits
    always_comb begin
      r_next = rem[k];
      q_next = nq[k];
      t = '0;
      for (int j = 0; j < DIV_BPS; j++) begin
        t = {r_next[DEN_W-1:0], q_next[NUM_W-1]};
        q_next = {q_next[NUM_W-2:0], 1'b0};
        if (t >= {1'b0, dv[k]}) begin
          t = t - {1'b0, dv[k]};
          q_next[0] = 1'b1;
        end
        r_next = t;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= r_next;
        nq[k+1]  <= q_next;
        dv[k+1]  <= dv[k];
        ng[k+1]  <= ng[k];
      end
    end
  end

  assign quo     = nq[DIV_STAGES];
  assign quo_neg = ng[DIV_STAGES];
endmodule
`default_nettype wire

// File: src/wcp_lane.sv
`default_nettype none
// One corner: scale, three rotations, perspective divide, center offset.
module wcp_lane (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire wcp_pkg::trig_t               trig,
  input  wire logic [2:0]                   corner,
  input  wire logic [wcp_pkg::HALF_W-1:0]   half_size,
  input  wire logic [wcp_pkg::CTR_W-1:0]    center_x,
  input  wire logic [wcp_pkg::CTR_W-1:0]    center_y,
  output logic signed [wcp_pkg::PIX_W-1:0]  px,
  output logic signed [wcp_pkg::PIX_W-1:0]  py
);
  import wcp_pkg::*;

  logic [2:0]               sgn;
  logic signed [8:0]        s, x0, y0, z0;
  logic signed [SUM_W-1:0]  x1_sum, z1_sum, y2_sum, z2_sum, x3_sum, y3_sum;
  logic signed [12:0]       dsum;
  logic signed [20:0]       nx, ny;

  // stage registers
  logic signed [8:0]         r1_y0;
  logic signed [COORD_W-1:0] r1_x1, r1_z1;
  trig_t                     r1_trig;
  logic signed [COORD_W-1:0] r2_x1, r2_y2, r2_z2;
  trig_t                     r2_trig;
  logic signed [COORD_W-1:0] r3_x3, r3_y3;
  logic [DEN_W-1:0]          r3_depth;
  logic [NUM_W-1:0]          r4_mx, r4_my;
  logic                      r4_nx, r4_ny;
  logic [DEN_W-1:0]          r4_depth;
  logic [NUM_W-1:0]          qx, qy;
  logic                      qx_neg, qy_neg;
  logic [NUM_W-1:0]          tx, ty;

  // corner scaled by half size
  assign sgn = corner_signs(corner);
  assign s   = $signed({2'b00, half_size});
  assign x0  = sgn[0] ? s : -s;
  assign y0  = sgn[1] ? s : -s;
  assign z0  = sgn[2] ? s : -s;

  // yaw
  assign x1_sum = x0 * trig.cy + z0 * trig.sy;
  assign z1_sum = z0 * trig.cy - x0 * trig.sy;
  // pitch
  assign y2_sum = r1_y0 * r1_trig.cx - r1_z1 * r1_trig.sx;
  assign z2_sum = r1_y0 * r1_trig.sx + r1_z1 * r1_trig.cx;
  // roll and depth
  assign x3_sum = r2_x1 * r2_trig.cz - r2_y2 * r2_trig.sz;
  assign y3_sum = r2_x1 * r2_trig.sz + r2_y2 * r2_trig.cz;
  assign dsum   = 13'(r2_z2) + DEPTH_BIAS;
  // numerators
  assign nx = r3_x3 * FOCAL;
  assign ny = r3_y3 * FOCAL;

  always_ff @(posedge clk) begin
    if (en) begin
      r1_x1    <= x1_sum[8 +: COORD_W];
      r1_z1    <= z1_sum[8 +: COORD_W];
      r1_y0    <= y0;
      r1_trig  <= trig;
      r2_x1    <= r1_x1;
      r2_y2    <= y2_sum[8 +: COORD_W];
      r2_z2    <= z2_sum[8 +: COORD_W];
      r2_trig  <= r1_trig;
      r3_x3    <= x3_sum[8 +: COORD_W];
      r3_y3    <= y3_sum[8 +: COORD_W];
      r3_depth <= (dsum < DEPTH_MIN) ? DEN_W'(DEPTH_MIN) : dsum[DEN_W-1:0];
      r4_nx    <= nx[20];
      r4_ny    <= ny[20];
      r4_mx    <= nx[20] ? NUM_W'(-nx) : nx[NUM_W-1:0];
      r4_my    <= ny[20] ? NUM_W'(-ny) : ny[NUM_W-1:0];
      r4_depth <= r3_depth;
    end
  end

  wcp_div u_div_x (
    .clk(clk), .en(en), .num(r4_mx), .den(r4_depth), .neg(r4_nx),
    .quo(qx), .quo_neg(qx_neg)
  );
  wcp_div u_div_y (
    .clk(clk), .en(en), .num(r4_my), .den(r4_depth), .neg(r4_ny),
    .quo(qy), .quo_neg(qy_neg)
  );

  // restore sign (truncating divide) and offset by center
  assign tx = qx_neg ? (~qx + 1'b1) : qx;
  assign ty = qy_neg ? (~qy + 1'b1) : qy;

  always_ff @(posedge clk) begin
    if (en) begin
      px <= $signed({3'b000, center_x} + tx[PIX_W-1:0]);
      py <= $signed({3'b000, center_y} + ty[PIX_W-1:0]);
    end
  end
endmodule
`default_nettype wire

// File: src/wireframe_cube_projector.sv
`default_nettype none
// Wireframe cube projector.
// angles (sink): one item per frame with yaw, pitch and roll, 256 steps per turn.
// edges (source): twelve items per frame, the projected endpoints of each cube
//   edge in fixed order; last_edge marks the twelfth.
// APB port: center_x at 0x0, center_y at 0x4, half_size at 0x8; write only
//   while the block is idle, reads return the current value.
// Throughput: one edge per cycle while edges.ready does not stall; the next frame
//   is taken in the cycle its predecessor's last edge is issued.
// Pipeline: issue stage, three rotation stages, numerator stage, ten divider
//   stages of two quotient bits each, offset/output stage.
// Each edge runs two corner lanes side by side, one per endpoint.
// Reset: clears the pipeline valid bits and the issue counter and loads the
//   register defaults (320, 290, 40).
// Stall: when edges.ready is low with a result waiting, the whole pipeline
//   holds; nothing is dropped or repeated.
module wireframe_cube_projector (
  input  wire logic                            clk,
  input  wire logic                            rst,
  wcp_in_if.sink                               angles,
  wcp_out_if.source                            edges,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [wcp_pkg::REG_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);
  import wcp_pkg::*;

  logic [CTR_W-1:0]   center_x, center_y;
  logic [HALF_W-1:0]  half_size;
  logic [ANGLE_W-1:0] yaw, pitch, roll;
  logic               busy;
  logic [EDGE_W-1:0]  cnt;
  logic               en, accept, issue_last;
  logic [PIPE_LEN-1:0] vld, lst;
  trig_t              s0_trig;
  logic [2:0]         s0_ca, s0_cb;
  logic [5:0]         pair;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x  <= CENTER_X_RST;
      center_y  <= CENTER_Y_RST;
      half_size <= HALF_SIZE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_CENTER_X:  center_x  <= pwdata[CTR_W-1:0];
        REG_CENTER_Y:  center_y  <= pwdata[CTR_W-1:0];
        REG_HALF_SIZE: half_size <= pwdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CENTER_X:  prdata = 32'(center_x);
      REG_CENTER_Y:  prdata = 32'(center_y);
      REG_HALF_SIZE: prdata = 32'(half_size);
      default:       prdata = '0;
    endcase
  end

  // global advance: output empty or being taken
  assign en         = !vld[PIPE_LEN-1] || edges.ready;
  assign issue_last = busy && en && (cnt == LAST_EDGE);
  assign angles.ready = !busy || issue_last;
  assign accept     = angles.valid && angles.ready;
  assign pair       = edge_corners(cnt);

  // frame intake and edge issue counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      if (busy && en) cnt <= (cnt == LAST_EDGE) ? '0 : cnt + 1'b1;
      if (accept) busy <= 1'b1;
      else if (issue_last) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      yaw   <= angles.yaw_angle;
      pitch <= angles.pitch_angle;
      roll  <= angles.roll_angle;
    end
  end

  // issue stage: trig lookups and corner pair
  always_ff @(posedge clk) begin
    if (en) begin
      s0_trig <= '{sy: sine8(yaw),   cy: cosine8(yaw),
                   sx: sine8(pitch), cx: cosine8(pitch),
                   sz: sine8(roll),  cz: cosine8(roll)};
      s0_ca   <= pair[5:3];
      s0_cb   <= pair[2:0];
    end
  end

  // valid and last bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LEN-2:0], busy};
    end
  end

  always_ff @(posedge clk) begin
    if (en) lst <= {lst[PIPE_LEN-2:0], cnt == LAST_EDGE};
  end

  wcp_lane u_lane_a (
    .clk(clk), .en(en), .trig(s0_trig), .corner(s0_ca), .half_size(half_size),
    .center_x(center_x), .center_y(center_y),
    .px(edges.start_x), .py(edges.start_y)
  );
  wcp_lane u_lane_b (
    .clk(clk), .en(en), .trig(s0_trig), .corner(s0_cb), .half_size(half_size),
    .center_x(center_x), .center_y(center_y),
    .px(edges.end_x), .py(edges.end_y)
  );

  assign edges.valid     = vld[PIPE_LEN-1];
  assign edges.last_edge = lst[PIPE_LEN-1];

  // counter stays in range and is parked at zero when idle
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= LAST_EDGE) else $error("edge counter out of range");
  a_idle_cnt: assert property (@(posedge clk) disable iff (rst)
    !busy |-> cnt == '0) else $error("edge counter not parked while idle");
  // the last-edge flag sits on the final corner pair
  a_last_pair: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> (lst[0] == (s0_ca == 3'd3 && s0_cb == 3'd7)))
    else $error("last flag on wrong edge");
endmodule
`default_nettype wire

// File: bench/wireframe_cube_projector_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module wireframe_cube_projector_checker (
  input  wire logic clk,
  input  wire logic rst,
  wcp_in_if.sink    angles,
  wcp_out_if.sink   edges,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [wcp_pkg::REG_ADDR_W-1:0] paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic pready,
  output int        errors,
  output int        pending
);
  import wcp_pkg::*;

  typedef struct packed {
    logic signed [PIX_W-1:0] sx;
    logic signed [PIX_W-1:0] sy;
    logic signed [PIX_W-1:0] ex;
    logic signed [PIX_W-1:0] ey;
    logic                    last;
  } edge_t;

  localparam logic [2:0] CORNER_PAT [8] = '{3'd0, 3'd1, 3'd3, 3'd2, 3'd4, 3'd5, 3'd7, 3'd6};
  localparam logic [2:0] EDGE_A [12] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
                                         3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3};
  localparam logic [2:0] EDGE_B [12] = '{3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6,
                                         3'd7, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7};

  edge_t expected_edges[$];
  int cx_reg, cy_reg, half_reg;

  // full-turn sine from the quarter table, 8.8
  function automatic int sin_lut(input int a);
    a = a & 255;
    if (a <= 64) return QSINE[a];
    if (a <= 128) return QSINE[128 - a];
    if (a <= 192) return -int'(QSINE[a - 128]);
    return -int'(QSINE[256 - a]);
  endfunction

  function automatic int floor256(input int v);
    return v >>> 8;
  endfunction

  task automatic project_frame(input int yaw, input int pitch, input int roll);
    int sy, cy, sx, cx, sz, cz;
    int x0, y0, z0, x1, z1, y2, z2, x3, y3, dep;
    int px[8], py[8];
    edge_t e;
    sy = sin_lut(yaw);   cy = sin_lut(yaw + 64);
    sx = sin_lut(pitch); cx = sin_lut(pitch + 64);
    sz = sin_lut(roll);  cz = sin_lut(roll + 64);
    for (int i = 0; i < 8; i++) begin
      x0 = CORNER_PAT[i][0] ? half_reg : -half_reg;
      y0 = CORNER_PAT[i][1] ? half_reg : -half_reg;
      z0 = CORNER_PAT[i][2] ? half_reg : -half_reg;
      x1 = floor256(x0 * cy + z0 * sy);
      z1 = floor256(-x0 * sy + z0 * cy);
      y2 = floor256(y0 * cx - z1 * sx);
      z2 = floor256(y0 * sx + z1 * cx);
      x3 = floor256(x1 * cz - y2 * sz);
      y3 = floor256(x1 * sz + y2 * cz);
      dep = z2 + 220;
      if (dep < 20) dep = 20;
      px[i] = cx_reg + (x3 * 200) / dep;
      py[i] = cy_reg + (y3 * 200) / dep;
    end
    for (int k = 0; k < 12; k++) begin
      e.sx = PIX_W'(px[EDGE_A[k]]);
      e.sy = PIX_W'(py[EDGE_A[k]]);
      e.ex = PIX_W'(px[EDGE_B[k]]);
      e.ey = PIX_W'(py[EDGE_B[k]]);
      e.last = (k == 11);
      expected_edges.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    edge_t w;
    if (rst) begin
      cx_reg <= CENTER_X_RST;
      cy_reg <= CENTER_Y_RST;
      half_reg <= HALF_SIZE_RST;
      errors <= 0;
      pending <= 0;
      expected_edges.delete();
    end else begin
      // register shadow
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_CENTER_X:  cx_reg <= pwdata[CTR_W-1:0];
          REG_CENTER_Y:  cy_reg <= pwdata[CTR_W-1:0];
          REG_HALF_SIZE: half_reg <= pwdata[HALF_W-1:0];
          default: ;
        endcase
      end
      if (angles.valid && angles.ready)
        project_frame(angles.yaw_angle, angles.pitch_angle, angles.roll_angle);
      // compare edges against oldest prediction
      if (edges.valid && edges.ready) begin
        if (expected_edges.size() == 0) begin
          $error("unexpected edge item");
          errors <= errors + 1;
        end else begin
          w = expected_edges.pop_front();
          if (edges.start_x !== w.sx || edges.start_y !== w.sy ||
              edges.end_x !== w.ex || edges.end_y !== w.ey ||
              edges.last_edge !== w.last) begin
            if (edges.start_x !== w.sx)
              $error("start_x exp %0d got %0d", w.sx, edges.start_x);
            if (edges.start_y !== w.sy)
              $error("start_y exp %0d got %0d", w.sy, edges.start_y);
            if (edges.end_x !== w.ex)
              $error("end_x exp %0d got %0d", w.ex, edges.end_x);
            if (edges.end_y !== w.ey)
              $error("end_y exp %0d got %0d", w.ey, edges.end_y);
            if (edges.last_edge !== w.last)
              $error("last_edge exp %0d got %0d", w.last, edges.last_edge);
            errors <= errors + 1;
          end
        end
      end
      // predicted items not yet seen
      pending <= expected_edges.size();
    end
  end
endmodule
`default_nettype wire

// File: bench/wireframe_cube_projector_test.sv
`timescale 1ns / 100ps
`default_nettype none
module wireframe_cube_projector_test;
  import wcp_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [REG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int errors, pending;
  int cycles = 0;
  bit hold_long = 0;
  bit stim_done = 0;

  wcp_in_if  angles ();
  wcp_out_if edges ();

  wireframe_cube_projector dut (
    .clk, .rst, .angles(angles.sink), .edges(edges.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  wireframe_cube_projector_checker chk (
    .clk, .rst, .angles(angles.sink), .edges(edges.sink),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .errors, .pending
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    angles.valid = 0;
    angles.yaw_angle = 0;
    angles.pitch_angle = 0;
    angles.roll_angle = 0;
    edges.ready = 0;
  end

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(19) == 0) return $urandom_range(60, 20);
    return $urandom_range(4, 1);
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    int g;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        edges.ready <= 0;
        repeat (150) @(posedge clk);
        hold_long = 0;
      end
      g = stim_done ? 0 : ($urandom_range(3) == 0 ? gap_len() : 0);
      if (g > 0) begin
        edges.ready <= 0;
        repeat (g) @(posedge clk);
      end
      edges.ready <= 1;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_frame(input logic [7:0] y, input logic [7:0] p, input logic [7:0] r);
    int g;
    g = gap_len();
    if (g > 0) begin
      angles.valid <= 0;
      repeat (g) @(posedge clk);
    end
    angles.valid <= 1;
    angles.yaw_angle <= y;
    angles.pitch_angle <= p;
    angles.roll_angle <= r;
    do @(posedge clk); while (!angles.ready);
  endtask

  // let the count of the last accepted frame settle before waiting on it
  task automatic drain();
    angles.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++)
      send_frame(8'($urandom), 8'($urandom), 8'($urandom));
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    // directed: default registers, angle extremes and quadrant edges
    send_frame(0, 0, 0);
    send_frame(8'hFF, 8'hFF, 8'hFF);
    send_frame(64, 0, 0);
    send_frame(0, 64, 0);
    send_frame(0, 0, 64);
    send_frame(128, 128, 128);
    send_frame(192, 192, 192);
    send_frame(32, 32, 32);
    send_frame(65, 129, 193);
    drain();
    // largest cube: near-plane clamp, then zero size and wide writes
    reg_write(REG_HALF_SIZE, 127);
    reg_write(REG_CENTER_X, 1023);
    reg_write(REG_CENTER_Y, 0);
    send_frame(0, 0, 0);
    send_frame(32, 32, 0);
    send_frame(0, 96, 0);
    send_frame(224, 160, 32);
    drain();
    reg_write(REG_HALF_SIZE, 32'hFFFF_FF00);
    reg_write(REG_CENTER_X, 0);
    reg_write(REG_CENTER_Y, 32'hFFFF_FFFF);
    reg_write(2'd3, 32'h1234);
    send_frame(10, 20, 30);
    send_frame(0, 0, 0);
    drain();
    // random phases over several settings
    reg_write(REG_HALF_SIZE, 127);
    reg_write(REG_CENTER_X, 512);
    reg_write(REG_CENTER_Y, 512);
    random_phase(60);
    reg_write(REG_HALF_SIZE, 1);
    random_phase(30);
    reg_write(REG_HALF_SIZE, $urandom_range(127));
    reg_write(REG_CENTER_X, $urandom_range(1023));
    reg_write(REG_CENTER_Y, $urandom_range(1023));
    hold_long = 1;
    random_phase(80);
    reg_write(REG_HALF_SIZE, 40);
    reg_write(REG_CENTER_X, 320);
    reg_write(REG_CENTER_Y, 290);
    random_phase(70);
    stim_done = 1;
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
